[rtl/fesp_pkg.sv]
package fesp_pkg;

  // Line store geometry and register widths.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HEAT_W     = 8;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  // Wide enough to hold either maximum and the sums of a position with two.
  localparam int DIM_W      = ((LINE_AW > ROW_W) ? LINE_AW : ROW_W) + 2;
  // Width of the four-neighbor heat sum.
  localparam int SUM_W      = HEAT_W + 2;

  localparam int MIN_WIDTH      = 3;
  localparam int MIN_HEIGHT     = 14;
  localparam int BAND_ROW_FIRST = 11;

  localparam logic [CFG_W-1:0]  WIDTH_RESET  = CFG_W'(1920);
  localparam logic [CFG_W-1:0]  HEIGHT_RESET = CFG_W'(1080);
  localparam logic [HEAT_W-1:0] THR_RESET    = HEAT_W'(10);
  localparam logic [HEAT_W-1:0] AMT_RESET    = HEAT_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH   = 2'd0,
    CFG_ACTIVE_HEIGHT  = 2'd1,
    CFG_FADE_THRESHOLD = 2'd2,
    CFG_FADE_AMOUNT    = 2'd3
  } cfg_idx_e;

  // Position of an accepted pixel, as the line stores and the stencil need it.
  typedef struct packed {
    logic               band;
    logic [LINE_AW-1:0] x;
    logic [LINE_AW-1:0] x_next;
  } pos_t;

  // Write-back to both line stores.
  typedef struct packed {
    logic                  we;
    logic [LINE_AW-1:0]    addr;
    logic [2*HEAT_W-1:0]   data_a;
    logic [HEAT_W-1:0]     data_b;
  } wr_t;

  // Fire palette, returned as {blue, green, red}.
  function automatic logic [3*HEAT_W-1:0] palette(input logic [HEAT_W-1:0] h);
    logic [HEAT_W-1:0] r;
    logic [HEAT_W-1:0] g;
    logic [HEAT_W-1:0] b;
    r = '0;
    g = '0;
    b = '0;
    if (h == '0) begin
      r = '0;
    end else if (h[7:6] == 2'b00) begin
      r = {h[5:0], 2'b00};
    end else if (h[7:6] == 2'b01) begin
      r = '1;
      g = {1'b0, h[5:0], 1'b0};
    end else if (h[7:6] == 2'b10) begin
      r = '1;
      g = h;
      b = {1'b0, h[6:0]};
    end else begin
      r = '1;
      g = '1;
      b = '1;
    end
    return {b, g, r};
  endfunction

endpackage

[rtl/fesp_ram.sv]
// Simple dual-port RAM: one write port, one registered read port, read-first.
module fesp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fesp_pos.sv]
// Column and row counters; decides the update band and the line store addresses.
module fesp_pos (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              frame_start_i,
  input  logic [fesp_pkg::CFG_W-1:0]        active_width_i,
  input  logic [fesp_pkg::CFG_W-1:0]        active_height_i,
  output fesp_pkg::pos_t                    pos_o
);

  logic [fesp_pkg::LINE_AW-1:0] col_q, col_d;
  logic [fesp_pkg::ROW_W-1:0]   row_q, row_d;
  logic [fesp_pkg::LINE_AW-1:0] x;
  logic [fesp_pkg::ROW_W-1:0]   y;
  logic [fesp_pkg::DIM_W-1:0]   wc, hc, xe, ye, w_raw, h_raw;
  logic                         last_col, last_row;

  // Clamp the line and frame sizes to the supported range.
  always_comb begin
    w_raw = fesp_pkg::DIM_W'(active_width_i);
    h_raw = fesp_pkg::DIM_W'(active_height_i);
    if (w_raw < fesp_pkg::DIM_W'(fesp_pkg::MIN_WIDTH)) begin
      wc = fesp_pkg::DIM_W'(fesp_pkg::MIN_WIDTH);
    end else if (w_raw > fesp_pkg::DIM_W'(fesp_pkg::MAX_WIDTH)) begin
      wc = fesp_pkg::DIM_W'(fesp_pkg::MAX_WIDTH);
    end else begin
      wc = w_raw;
    end
    if (h_raw < fesp_pkg::DIM_W'(fesp_pkg::MIN_HEIGHT)) begin
      hc = fesp_pkg::DIM_W'(fesp_pkg::MIN_HEIGHT);
    end else if (h_raw > fesp_pkg::DIM_W'(fesp_pkg::MAX_HEIGHT)) begin
      hc = fesp_pkg::DIM_W'(fesp_pkg::MAX_HEIGHT);
    end else begin
      hc = h_raw;
    end
  end

  // A frame start puts the current pixel at the origin.
  assign x  = frame_start_i ? '0 : col_q;
  assign y  = frame_start_i ? '0 : row_q;
  assign xe = fesp_pkg::DIM_W'(x);
  assign ye = fesp_pkg::DIM_W'(y);

  assign last_col = (xe + fesp_pkg::DIM_W'(1)) >= wc;
  assign last_row = (ye + fesp_pkg::DIM_W'(1)) >= hc;

  assign pos_o.band = (x != '0) && ((xe + fesp_pkg::DIM_W'(2)) <= wc)
                   && (ye >= fesp_pkg::DIM_W'(fesp_pkg::BAND_ROW_FIRST))
                   && ((ye + fesp_pkg::DIM_W'(1)) <= hc);
  assign pos_o.x      = x;
  assign pos_o.x_next = x + fesp_pkg::LINE_AW'(1);

  // Advance the raster position on each accepted beat.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : y + fesp_pkg::ROW_W'(1);
      end else begin
        col_d = x + fesp_pkg::LINE_AW'(1);
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/fesp_stencil.sv]
// Stencil stage: takes line store data, averages, fades, colors and writes back.
module fesp_stencil (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [fesp_pkg::HEAT_W-1:0]     heat_i,
  input  fesp_pkg::pos_t                  pos_i,
  input  logic [2*fesp_pkg::HEAT_W-1:0]   rdata_a_i,
  input  logic [fesp_pkg::HEAT_W-1:0]     rdata_b_i,
  input  logic [fesp_pkg::HEAT_W-1:0]     fade_threshold_i,
  input  logic [fesp_pkg::HEAT_W-1:0]     fade_amount_i,
  output fesp_pkg::wr_t                   wr_o,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [4*fesp_pkg::HEAT_W-1:0]   out_data_o
);

  logic                            s1_valid_q;
  logic [fesp_pkg::HEAT_W-1:0]     s1_heat_q;
  logic [fesp_pkg::LINE_AW-1:0]    s1_x_q;
  logic                            s1_band_q;
  logic                            s1_adv;

  logic                            fwd_a_q, fwd_b_q;
  logic [2*fesp_pkg::HEAT_W-1:0]   fwd_a_data_q;
  logic [fesp_pkg::HEAT_W-1:0]     fwd_b_data_q;

  logic [fesp_pkg::HEAT_W-1:0]     left_hold_q;
  logic                            out_valid_q;
  logic [4*fesp_pkg::HEAT_W-1:0]   out_data_q;

  logic [2*fesp_pkg::HEAT_W-1:0]   entry_a;
  logic [fesp_pkg::HEAT_W-1:0]     prev_old, prev2_old, prev_right;
  logic [fesp_pkg::SUM_W-1:0]      sum;
  logic [fesp_pkg::HEAT_W-1:0]     avg, res;

  // The stage moves on when the output register is free or being emptied.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Line store data, with the write of the previous pixel forwarded.
  assign entry_a    = fwd_a_q ? fwd_a_data_q : rdata_a_i;
  assign prev_old   = entry_a[fesp_pkg::HEAT_W-1:0];
  assign prev2_old  = entry_a[2*fesp_pkg::HEAT_W-1:fesp_pkg::HEAT_W];
  assign prev_right = fwd_b_q ? fwd_b_data_q : rdata_b_i;

  // Shift the column down one line: old row y-1 moves to y-2, new heat to y-1.
  assign wr_o.we     = s1_valid_q && s1_adv;
  assign wr_o.addr   = s1_x_q;
  assign wr_o.data_a = {prev_old, s1_heat_q};
  assign wr_o.data_b = s1_heat_q;

  // Four-neighbor average with the fade, saturating at zero.
  always_comb begin
    sum = fesp_pkg::SUM_W'(left_hold_q) + fesp_pkg::SUM_W'(prev_right)
        + fesp_pkg::SUM_W'(prev2_old) + fesp_pkg::SUM_W'(s1_heat_q);
    avg = sum[fesp_pkg::SUM_W-1:2];
    if (!s1_band_q) begin
      res = '0;
    end else if (avg > fade_threshold_i) begin
      res = (avg > fade_amount_i) ? avg - fade_amount_i : '0;
    end else begin
      res = avg;
    end
  end

  // Pixel in the stencil stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_heat_q <= heat_i;
      s1_x_q    <= pos_i.x;
      s1_band_q <= pos_i.band;
    end
  end

  // Forwarding: a read issued while the older pixel writes the same entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (accept_i) begin
      fwd_a_q <= wr_o.we && (s1_x_q == pos_i.x);
      fwd_b_q <= wr_o.we && (s1_x_q == pos_i.x_next);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fwd_a_data_q <= wr_o.data_a;
      fwd_b_data_q <= wr_o.data_b;
    end
  end

  // Row y-1 heat one column to the left, kept from the previous pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hold_q <= '0;
    end else if (wr_o.we) begin
      left_hold_q <= prev_old;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_o.we) begin
      out_data_q <= {fesp_pkg::palette(res), res};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/fire_effect_stencil_palette_top.sv]
// Fire effect stencil with fire palette. Heat pixels stream in raster order, one
// beat per pixel; each input beat at column x, row y gives one output beat holding
// the next frame's heat at column x, row y-1 and its palette color. The block takes
// one pixel per clock cycle unless the output stalls, as both line stores are read
// once and written once per cycle; each beat passes the stencil and output
// registers. There is no clearing pass after reset: the line stores must be filled
// by two rows of pixels before their contents reach an output. Output heat is zero
// on the left and right border columns and outside the update rows. The user must
// write configuration only while the block is idle; the block does not enforce it.
module fire_effect_stencil_palette_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] heat_in
  input  logic                               s_axis_tuser,   // [0] frame_start
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,   // [7:0] heat_out,
                                                             // [15:8] red, [23:16] green,
                                                             // [31:24] blue
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [fesp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fesp_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [fesp_pkg::CFG_W-1:0]          active_width_q;
  logic [fesp_pkg::CFG_W-1:0]          active_height_q;
  logic [fesp_pkg::HEAT_W-1:0]         fade_threshold_q;
  logic [fesp_pkg::HEAT_W-1:0]         fade_amount_q;

  logic                                accept;
  fesp_pkg::pos_t                      pos;
  fesp_pkg::wr_t                       wr;
  logic [2*fesp_pkg::HEAT_W-1:0]       rdata_a;
  logic [fesp_pkg::HEAT_W-1:0]         rdata_b;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q   <= fesp_pkg::WIDTH_RESET;
      active_height_q  <= fesp_pkg::HEIGHT_RESET;
      fade_threshold_q <= fesp_pkg::THR_RESET;
      fade_amount_q    <= fesp_pkg::AMT_RESET;
    end else if (cfg_we_i) begin
      unique case (fesp_pkg::cfg_idx_e'(cfg_idx_i))
        fesp_pkg::CFG_ACTIVE_WIDTH:   active_width_q   <= cfg_data_i;
        fesp_pkg::CFG_ACTIVE_HEIGHT:  active_height_q  <= cfg_data_i;
        fesp_pkg::CFG_FADE_THRESHOLD: fade_threshold_q <= cfg_data_i[fesp_pkg::HEAT_W-1:0];
        fesp_pkg::CFG_FADE_AMOUNT:    fade_amount_q    <= cfg_data_i[fesp_pkg::HEAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  fesp_pos u_pos (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .frame_start_i   (s_axis_tuser),
    .active_width_i  (active_width_q),
    .active_height_i (active_height_q),
    .pos_o           (pos)
  );

  // Line store A: {row y-2, row y-1} per column, read at the current column.
  fesp_ram #(
    .WIDTH (2*fesp_pkg::HEAT_W),
    .DEPTH (fesp_pkg::MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data_a),
    .re_i    (accept),
    .raddr_i (pos.x),
    .rdata_o (rdata_a)
  );

  // Line store B: copy of row y-1, read one column to the right.
  fesp_ram #(
    .WIDTH (fesp_pkg::HEAT_W),
    .DEPTH (fesp_pkg::MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data_b),
    .re_i    (accept),
    .raddr_i (pos.x_next),
    .rdata_o (rdata_b)
  );

  fesp_stencil u_stencil (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .heat_i           (s_axis_tdata),
    .pos_i            (pos),
    .rdata_a_i        (rdata_a),
    .rdata_b_i        (rdata_b),
    .fade_threshold_i (fade_threshold_q),
    .fade_amount_i    (fade_amount_q),
    .wr_o             (wr),
    .in_ready_o       (s_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (m_axis_tdata)
  );

endmodule

[rtl/fesp_checker.sv]
// Port-level checks of the fire effect block.
module fesp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled output beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // The pipeline never stops the input while the output side drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // Zero heat shows as black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0) |-> (m_axis_tdata[31:8] == 24'd0))
    else $error("zero heat is not black");

  // The hottest quarter of the range shows as white.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:6] == 2'b11) |-> (m_axis_tdata[31:8] == 24'hFFFFFF))
    else $error("hot pixel is not white");

endmodule

bind fire_effect_stencil_palette_top fesp_checker u_fesp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
